// ===== rtl/core/gradient_focus_metric_top_k_core_assert.svh =====
// Assertion macros shared by the focus metric core.
`ifndef GRADIENT_FOCUS_METRIC_TOP_K_CORE_ASSERT_SVH
`define GRADIENT_FOCUS_METRIC_TOP_K_CORE_ASSERT_SVH
// Implication that must hold at every clock edge outside reset.
`define GFM_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define GFM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// ===== rtl/core/gfm_pkg.sv =====
// ---------------------------------------------------------------------------
// gfm_pkg
// Types and constants shared by the focus metric core.
// ---------------------------------------------------------------------------
`default_nettype none
package gfm_pkg;
    localparam int METRIC_BITS = 38;
    localparam int GAIN_BITS = 39;
    localparam int COORD_BITS = 10;
    localparam logic [METRIC_BITS-1:0] METRIC_MAX = {METRIC_BITS{1'b1}};
    localparam logic [2:0] REG_WIDTH = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_POINTS = 3'd2;
    localparam logic [2:0] REG_DELTA = 3'd3;
    localparam logic [2:0] REG_FRAMES = 3'd4;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_POINT = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/core/gfm_cell.sv =====
// ---------------------------------------------------------------------------
// gfm_cell
// One slot of the sorted top-k chain; takes a candidate or the left neighbor.
// ---------------------------------------------------------------------------
`default_nettype none
module gfm_cell #(
    parameter int PIXEL_BITS = 16,
    parameter int CB = 10
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         clear,
    input  wire                         ins,
    input  wire                         shift,
    input  wire signed [PIXEL_BITS-1:0] cand_value,
    input  wire [CB-1:0]                cand_row,
    input  wire [CB-1:0]                cand_col,
    input  wire                         left_valid,
    input  wire                         left_ge,
    input  wire signed [PIXEL_BITS-1:0] left_value,
    input  wire [CB-1:0]                left_row,
    input  wire [CB-1:0]                left_col,
    input  wire                         keep,
    output logic                        valid,
    output logic                        ge,
    output logic signed [PIXEL_BITS-1:0] value,
    output logic [CB-1:0]               row,
    output logic [CB-1:0]               col
);
    logic valid_reg;
    logic signed [PIXEL_BITS-1:0] value_reg;
    logic [CB-1:0] row_reg, col_reg;

    assign valid = valid_reg;
    assign value = value_reg;
    assign row = row_reg;
    assign col = col_reg;
    assign ge = valid_reg && (value_reg >= cand_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= left_valid && keep;
        end
        else if (ins && !ge && keep)
        begin
            valid_reg <= left_ge || left_valid;
        end
        else if (!keep)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= left_value;
            row_reg <= left_row;
            col_reg <= left_col;
        end
        else if (ins && !ge)
        begin
            if (left_ge)
            begin
                value_reg <= cand_value;
                row_reg <= cand_row;
                col_reg <= cand_col;
            end
            else
            begin
                value_reg <= left_value;
                row_reg <= left_row;
                col_reg <= left_col;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/gfm_grad.sv =====
// ---------------------------------------------------------------------------
// gfm_grad
// Left-pixel register and saturating gradient accumulator.
// ---------------------------------------------------------------------------
`default_nettype none
module gfm_grad #(
    parameter int PIXEL_BITS = 16,
    parameter int AW = 10
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          acc,
    input  wire                          use_grad,
    input  wire                          clear,
    input  wire [AW-1:0]                 col,
    input  wire signed [PIXEL_BITS-1:0]  pixel,
    input  wire signed [PIXEL_BITS-1:0]  above,
    output logic [gfm_pkg::METRIC_BITS-1:0] metric
);
    logic signed [PIXEL_BITS-1:0] left_reg;
    logic [gfm_pkg::METRIC_BITS-1:0] sum_reg;
    logic signed [PIXEL_BITS:0] dl, du;
    logic [PIXEL_BITS:0] al, au;
    logic [gfm_pkg::METRIC_BITS:0] s;

    assign metric = sum_reg;
    always_comb
    begin
        dl = {pixel[PIXEL_BITS-1], pixel} - {left_reg[PIXEL_BITS-1], left_reg};
        du = {pixel[PIXEL_BITS-1], pixel} - {above[PIXEL_BITS-1], above};
        al = dl[PIXEL_BITS] ? -dl : dl;
        au = du[PIXEL_BITS] ? -du : du;
        s = {1'b0, sum_reg} + (gfm_pkg::METRIC_BITS+1)'(al)
            + (gfm_pkg::METRIC_BITS+1)'(au);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            sum_reg <= '0;
        end
        else if (clear)
        begin
            sum_reg <= '0;
        end
        else if (acc)
        begin
            left_reg <= pixel;
            if (use_grad && col != '0)
            begin
                sum_reg <= s[gfm_pkg::METRIC_BITS] ? gfm_pkg::METRIC_MAX
                                                  : s[gfm_pkg::METRIC_BITS-1:0];
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/gradient_focus_metric_top_k_core.sv =====
// ---------------------------------------------------------------------------
// gradient_focus_metric_top_k_core
// Gradient focus metric with sorted top-k pixel selection.
// ---------------------------------------------------------------------------
// channel | direction | handshake      | payload
// pixel   | in        | valid/stall    | pixel
// result  | out       | valid/stall    | item_kind .. last
// cfg     | in        | APB            | five registers
// For each pixel the line buffer read is registered in ST_IDLE, then the
// gradient add and the chain insert happen in ST_PROC.
// At frame end the block emits one summary and up to max_points points, one
// per cycle while the output is not stalled, and accepts no pixel meanwhile.
// Reset clears counters, metric, best and the chain valid bits.
`default_nettype none
module gradient_focus_metric_top_k_core #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_POINTS = 16,
    parameter int PIXEL_BITS = 16
) (
    input  wire clk,
    input  wire rst_n,
    input  wire psel,
    input  wire penable,
    input  wire pwrite,
    input  wire [5:0] paddr,
    input  wire [63:0] pwdata,
    output logic [63:0] prdata,
    output logic pready,
    input  wire in_valid,
    output logic in_stall,
    input  wire signed [PIXEL_BITS-1:0] pixel,
    output logic out_valid,
    input  wire out_stall,
    output logic item_kind,
    output logic [31:0] frame_number,
    output logic [37:0] focus_metric,
    output logic signed [38:0] metric_gain,
    output logic is_best,
    output logic converged,
    output logic [9:0] point_row,
    output logic [9:0] point_col,
    output logic signed [PIXEL_BITS-1:0] point_value,
    output logic last
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT);
    localparam int KW = $clog2(MAX_POINTS+1);
    localparam int MB = gfm_pkg::METRIC_BITS;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PROC = 2'd1;
    localparam logic [1:0] ST_SUM = 2'd2;
    localparam logic [1:0] ST_PTS = 2'd3;

    logic [10:0] width_reg, height_reg;
    logic [4:0] points_reg;
    logic [MB-1:0] delta_reg;
    logic [31:0] frames_reg;
    logic [1:0] state_reg;
    logic [AW-1:0] col_reg;
    logic [HW-1:0] row_reg;
    logic signed [PIXEL_BITS-1:0] pix_reg, above_reg;
    logic [MB-1:0] best_reg;
    logic [31:0] fcount_reg;
    logic signed [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [12:0] w_eff, h_eff;
    logic [KW-1:0] k_eff;
    logic [MB-1:0] metric;
    logic cfg_wr, end_row, end_frame, clear;
    logic [MAX_POINTS:0] cv, cg;
    logic signed [PIXEL_BITS-1:0] cval [MAX_POINTS+1];
    logic [9:0] crow [MAX_POINTS+1], ccol [MAX_POINTS+1];
    logic signed [MB:0] gain;
    logic [32:0] fc1;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        case (paddr[5:3])
            gfm_pkg::REG_WIDTH:  prdata = {53'd0, width_reg};
            gfm_pkg::REG_HEIGHT: prdata = {53'd0, height_reg};
            gfm_pkg::REG_POINTS: prdata = {59'd0, points_reg};
            gfm_pkg::REG_DELTA:  prdata = {26'd0, delta_reg};
            gfm_pkg::REG_FRAMES: prdata = {32'd0, frames_reg};
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        w_eff = (width_reg == 0) ? 13'd1 : (width_reg > MAX_WIDTH) ? 13'(MAX_WIDTH)
                                                                  : 13'(width_reg);
        h_eff = (height_reg == 0) ? 13'd1 : (height_reg > MAX_HEIGHT) ? 13'(MAX_HEIGHT)
                                                                      : 13'(height_reg);
        k_eff = (points_reg > MAX_POINTS) ? KW'(MAX_POINTS) : KW'(points_reg);
        end_row = 13'(col_reg) + 13'd1 >= w_eff;
        end_frame = end_row && (13'(row_reg) + 13'd1 >= h_eff);
        clear = (state_reg == ST_SUM) && !out_stall;
        gain = {1'b0, metric} - {1'b0, best_reg};
        fc1 = {1'b0, fcount_reg} + 33'd1;
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd1024;
            height_reg <= 11'd1024;
            points_reg <= 5'd16;
            delta_reg <= '0;
            frames_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[5:3])
                gfm_pkg::REG_WIDTH:  width_reg <= pwdata[10:0];
                gfm_pkg::REG_HEIGHT: height_reg <= pwdata[10:0];
                gfm_pkg::REG_POINTS: points_reg <= pwdata[4:0];
                gfm_pkg::REG_DELTA:  delta_reg <= pwdata[MB-1:0];
                gfm_pkg::REG_FRAMES: frames_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            pix_reg <= pixel;
            above_reg <= line_mem[col_reg];
        end
        if (state_reg == ST_PROC)
        begin
            line_mem[col_reg] <= pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            best_reg <= '0;
            fcount_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_PROC;
                    end
                end
                ST_PROC:
                begin
                    if (end_frame)
                    begin
                        state_reg <= ST_SUM;
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        col_reg <= end_row ? '0 : col_reg + AW'(1);
                        row_reg <= end_row ? row_reg + HW'(1) : row_reg;
                    end
                end
                ST_SUM:
                begin
                    if (!out_stall)
                    begin
                        if (metric >= best_reg)
                        begin
                            best_reg <= metric;
                        end
                        state_reg <= (cv[1] && k_eff != 0) ? ST_PTS : ST_IDLE;
                        if (!(cv[1] && k_eff != 0))
                        begin
                            fcount_reg <= fcount_reg + 32'd1;
                        end
                    end
                end
                ST_PTS:
                begin
                    if (!out_stall)
                    begin
                        if (last)
                        begin
                            state_reg <= ST_IDLE;
                            fcount_reg <= fcount_reg + 32'd1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    gfm_grad #(.PIXEL_BITS(PIXEL_BITS), .AW(AW)) u_grad (
        .clk(clk), .rst_n(rst_n), .acc(state_reg == ST_PROC),
        .use_grad(row_reg != '0), .clear(clear), .col(col_reg),
        .pixel(pix_reg), .above(above_reg), .metric(metric)
    );

    assign cv[0] = 1'b1;
    assign cg[0] = 1'b1;
    assign cval[0] = pix_reg;
    assign crow[0] = 10'(row_reg);
    assign ccol[0] = 10'(col_reg);

    genvar gi;
    generate
        for (gi = 1; gi <= MAX_POINTS; gi++)
        begin : g_chain
            logic ok;
            logic lg;
            assign ok = KW'(gi) <= k_eff;
            assign lg = (gi == 1) ? 1'b1 : cg[gi-1];
            gfm_cell #(.PIXEL_BITS(PIXEL_BITS), .CB(10)) u_cell (
                .clk(clk), .rst_n(rst_n),
                .clear(clear && last), .ins(state_reg == ST_PROC),
                .shift(state_reg == ST_PTS && !out_stall),
                .cand_value(pix_reg), .cand_row(crow[0]), .cand_col(ccol[0]),
                .left_valid(state_reg == ST_PTS ?
                            ((gi == MAX_POINTS) ? 1'b0 : cv[(gi % MAX_POINTS) + 1])
                            : cv[gi-1]),
                .left_ge(lg),
                .left_value(state_reg == ST_PTS ?
                            cval[(gi == MAX_POINTS) ? gi : gi + 1] : cval[gi-1]),
                .left_row(state_reg == ST_PTS ?
                          crow[(gi == MAX_POINTS) ? gi : gi + 1] : crow[gi-1]),
                .left_col(state_reg == ST_PTS ?
                          ccol[(gi == MAX_POINTS) ? gi : gi + 1] : ccol[gi-1]),
                .keep(ok),
                .valid(cv[gi]), .ge(cg[gi]),
                .value(cval[gi]), .row(crow[gi]), .col(ccol[gi])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid = (state_reg == ST_SUM) || (state_reg == ST_PTS);
        item_kind = (state_reg == ST_PTS) ? gfm_pkg::KIND_POINT : gfm_pkg::KIND_SUMMARY;
        frame_number = fcount_reg;
        focus_metric = '0;
        metric_gain = '0;
        is_best = 1'b0;
        converged = 1'b0;
        point_row = '0;
        point_col = '0;
        point_value = '0;
        last = 1'b0;
        if (state_reg == ST_SUM)
        begin
            focus_metric = metric;
            metric_gain = gain;
            is_best = metric >= best_reg;
            converged = (delta_reg != '0 && (gain[MB] || gain[MB-1:0] < delta_reg))
                     || (frames_reg != '0 && fc1 >= {1'b0, frames_reg});
            last = !(cv[1] && k_eff != 0);
        end
        else if (state_reg == ST_PTS)
        begin
            point_row = crow[1];
            point_col = ccol[1];
            point_value = cval[1];
            last = (MAX_POINTS == 1) ? 1'b1 : !cv[(MAX_POINTS == 1) ? 1 : 2];
        end
    end

    `include "gradient_focus_metric_top_k_core_assert.svh"
    `GFM_ASSERT_IMP(a_no_in_busy, clk, rst_n, state_reg != ST_IDLE, in_stall, "busy accept")
    `GFM_ASSERT_IMP(a_pts_valid, clk, rst_n, state_reg == ST_PTS, cv[1], "empty point")
    `GFM_ASSERT_NEXT(a_sum_hold, clk, rst_n, state_reg == ST_SUM && out_stall,
                     state_reg == ST_SUM, "summary lost")
endmodule
`default_nettype wire
